/* design/double_ended_queue_defines.svh */
// assertion macros for the double-ended queue checker
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dq_pkg.sv */
// shared types and constants of the double-ended queue
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } dq_cmd_t;

endpackage

`default_nettype wire

/* design/dq_if.sv */
// handshake channels of the double-ended queue
`default_nettype none

interface dq_in_if import dq_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface dq_out_if import dq_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] popped_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        fill_count;

  modport source (output valid, output popped_value, output status, output fill_count,
                  input ready);
  modport sink (input valid, input popped_value, input status, input fill_count,
                output ready);
endinterface

`default_nettype wire

/* design/dq_ctrl.sv */
// controller state machine of the double-ended queue
`default_nettype none

module dq_ctrl import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_ready,
  output logic      out_valid,
  output dq_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.latch = in_valid && (state_r == S_IDLE);
    cmd.exec  = (state_r == S_EXEC);
    cmd.load  = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dq_datapath.sv */
// ring store, end indices, entry count and result register
`default_nettype none

module dq_datapath import dq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dq_cmd_t                   cmd,
  input  wire logic [OP_W-1:0]           in_operation,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic signed [VALUE_W-1:0]      out_popped_value,
  output status_t                        out_status,
  output logic [COUNT_W-1:0]             out_fill_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  op_t                   op_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t       status_r, status_nxt;
  logic          pop_ok_r, pop_ok_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          full, empty;

  logic signed [VALUE_W-1:0] popped_wide;
  logic [COUNT_W-1:0]        count_out;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  // stored sign extended or cut to DATA_WIDTH, popped cut or sign extended
  generate
    if (DATA_WIDTH >= VALUE_W) begin : g_wide
      assign word_in     = {{(DATA_WIDTH - VALUE_W + 1){in_value[VALUE_W-1]}},
                            in_value[VALUE_W-2:0]};
      assign popped_wide = rd_data_r[VALUE_W-1:0];
    end else begin : g_narrow
      assign word_in     = in_value[DATA_WIDTH-1:0];
      assign popped_wide = {{(VALUE_W - DATA_WIDTH){rd_data_r[DATA_WIDTH-1]}}, rd_data_r};
    end
  endgenerate

  generate
    if (CW >= COUNT_W) begin : g_cnt_trunc
      assign count_out = count_r[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_out = {{(COUNT_W - CW){1'b0}}, count_r};
    end
  endgenerate

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = back_r;
    rd_addr    = front_r;
    unique case (op_r)
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.exec;
          wr_addr   = back_r;
          back_nxt  = ring_next(back_r);
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.exec;
          wr_addr   = ring_prev(front_r);
          front_nxt = ring_prev(front_r);
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en      = cmd.exec;
          rd_addr    = ring_prev(back_r);
          back_nxt   = ring_prev(back_r);
          count_nxt  = count_r - CW'(1);
          pop_ok_nxt = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en      = cmd.exec;
          rd_addr    = front_r;
          front_nxt  = ring_next(front_r);
          count_nxt  = count_r - CW'(1);
          pop_ok_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // ring store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_operation);
      word_r <= word_in;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (cmd.load) begin
      out_popped_value <= pop_ok_r ? popped_wide : '0;
      out_status       <= status_r;
      out_fill_count   <= count_out;
    end
  end

endmodule

`default_nettype wire

/* design/double_ended_queue.sv */
// top level of the double-ended queue of signed words
// an item is latched when taken, executed on the ring in the execute step and its result loaded in the result step
// steps are take, execute and load result; a new item is taken only once the previous one has loaded its result
// a result waiting on out_if does not block the next item until that item reaches its result step
// reset: synchronous, active low; clears indices, entry count and handshake state
// the ring store is not cleared; no entry is ever popped before it was pushed
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dq_in_if.sink    in_if,
  dq_out_if.source out_if
);

  // command bundle from controller to datapath
  dq_cmd_t cmd;

  // result fields held in the datapath's output register
  logic signed [VALUE_W-1:0] dp_popped_value;
  status_t                   dp_status;
  logic [COUNT_W-1:0]        dp_fill_count;

  // controller: idle (item taken), execute (ring update, read issued),
  // result (load output register once it is free)
  dq_ctrl u_dq_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .cmd       (cmd)
  );

  // datapath: ring store with front and back indices and the entry count
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dq_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_if.operation),
    .in_value         (in_if.value),
    .out_popped_value (dp_popped_value),
    .out_status       (dp_status),
    .out_fill_count   (dp_fill_count)
  );

  // result item fields straight from the output register
  assign out_if.popped_value = dp_popped_value;
  assign out_if.status       = dp_status;
  assign out_if.fill_count   = dp_fill_count;

endmodule

`default_nettype wire

/* design/dq_checker.sv */
// port-level checks of the double-ended queue and their binding
`default_nettype none

`include "double_ended_queue_defines.svh"

module dq_checker import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [VALUE_W-1:0] out_popped_value,
  input wire logic [STATUS_W-1:0]       out_status,
  input wire logic [COUNT_W-1:0]        out_fill_count
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  `DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before taken")
  `DQ_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while one in work")
  `DQ_ASSERT_NOW(a_refused_zero, out_valid && (out_status != ST_DONE), out_popped_value == '0, "refused item gives nonzero word")
  `DQ_ASSERT_NOW(a_empty_count, out_valid && (out_status == ST_EMPTY), out_fill_count == '0, "empty refusal with entries held")
  `DQ_ASSERT_NOW(a_full_count, out_valid && (out_status == ST_FULL), out_fill_count == FULL_COUNT, "full refusal below depth")

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_popped_value (out_if.popped_value),
  .out_status       (out_if.status),
  .out_fill_count   (out_if.fill_count)
);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench of the double-ended queue: directed and random operations

import dq_pkg::*;

// one expected result of the queue
typedef struct {
  logic signed [VALUE_W-1:0] popped_value;
  status_t                   status;
  logic [COUNT_W-1:0]        fill_count;
} deque_result_t;

// shadow copy of the ring and the results still owed by the block
class deque_scoreboard;
  logic signed [VALUE_W-1:0] ring [DEPTH_DEF];
  int unsigned               head_slot;
  int unsigned               tail_slot;
  int unsigned               held;
  deque_result_t             owed_results[$];
  int unsigned               fails;

  function new();
    head_slot = 0;
    tail_slot = 0;
    held      = 0;
    fails     = 0;
  endfunction

  // work out the result of an accepted item and update the shadow ring
  function void note_operation(op_t op, logic signed [VALUE_W-1:0] word);
    deque_result_t r;
    r.popped_value = '0;
    r.status       = ST_DONE;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held == DEPTH_DEF) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          ring[tail_slot] = word;
          tail_slot       = (tail_slot + 1) % DEPTH_DEF;
          held++;
        end else begin
          head_slot       = (head_slot + DEPTH_DEF - 1) % DEPTH_DEF;
          ring[head_slot] = word;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_BACK) begin
          tail_slot      = (tail_slot + DEPTH_DEF - 1) % DEPTH_DEF;
          r.popped_value = ring[tail_slot];
          held--;
        end else begin
          r.popped_value = ring[head_slot];
          head_slot      = (head_slot + 1) % DEPTH_DEF;
          held--;
        end
      end
    endcase
    r.fill_count = COUNT_W'(held);
    owed_results.insert(owed_results.size(), r);
  endfunction

  // compare an accepted result with the oldest one owed
  function void check_result(logic signed [VALUE_W-1:0] popped_value,
                             logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] fill_count);
    deque_result_t want;
    if (owed_results.size() == 0) begin
      $error("result with no item waiting: popped_value %0d status %0d fill_count %0d",
             popped_value, status, fill_count);
      fails++;
      return;
    end
    want = owed_results[0];
    owed_results.delete(0);
    if (popped_value !== want.popped_value) begin
      $error("popped_value: expected %0d, got %0d", want.popped_value, popped_value);
      fails++;
    end
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      fails++;
    end
    if (fill_count !== want.fill_count) begin
      $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
      fails++;
    end
  endfunction
endclass

module testbench;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int GAP_PCT      = 35;    // chance of an idle cycle on either side
  localparam int RANDOM_ITEMS = 1525;
  localparam int QUIET_START  = 400;   // stretch of random items with no idling at all
  localparam int QUIET_END    = 650;
  localparam int HOLD_AT      = 900;   // item count at which the receiver holds off
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 10;    // extra wait after the last owed result has come out

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  deque_scoreboard sb = new();

  // flags shared between the sender, the receiver and the stimulus sequence, and the watchdog's count
  logic        no_gaps      = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // offer one item, with random idle cycles ahead of it; called and left at a falling edge
  task automatic offer_item(op_t op, logic signed [VALUE_W-1:0] word);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.value     = word;
    // the block stalls the input until it is back in its idle step
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operation(op, word);
    @(negedge clk);
  endtask

  // mostly random words, with the extremes now and then
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // push or pop at a random end, pushes taking push_pct of a hundred
  function automatic op_t pick_operation(int unsigned push_pct);
    logic at_back;
    at_back = 1'($urandom_range(1));
    if ($urandom_range(99) < push_pct) return at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return at_back ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // receiver: random back-pressure, one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_request) begin
      out_ch.ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_request = 1'b0;
    end
    out_ch.ready = no_gaps || ($urandom_range(99) >= GAP_PCT);
    @(posedge clk);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.popped_value, out_ch.status, out_ch.fill_count);
    end
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned phase_left;
    int unsigned push_pct;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH_BACK;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // pops on an empty queue are refused at both ends
    offer_item(OP_POP_BACK, '1);
    offer_item(OP_POP_FRONT, '0);
    // extremes at both ends; the first front push wraps the front index below zero
    offer_item(OP_PUSH_FRONT, {1'b1, {(VALUE_W-1){1'b0}}});
    offer_item(OP_PUSH_BACK, {1'b0, {(VALUE_W-1){1'b1}}});
    offer_item(OP_PUSH_FRONT, '1);
    offer_item(OP_PUSH_BACK, '0);
    offer_item(OP_POP_BACK, 32'h1234_5678);
    offer_item(OP_POP_FRONT, 32'h8765_4321);
    // fill up from both ends, then pushes are refused at both ends
    for (int i = 0; i < DEPTH_DEF - 2; i++) begin
      offer_item((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                 ((i / 2) % 2) ? 32'h5555_5555 : (32'hAAAA_AAAA ^ i));
    end
    offer_item(OP_PUSH_BACK, 32'h0F0F_0F0F);
    offer_item(OP_PUSH_FRONT, 32'hF0F0_F0F0);
    offer_item(OP_POP_FRONT, '0);

    // random part in phases that lean towards pushes or pops, so the queue
    // swings between full and empty and both indices wrap many times
    items_sent = 0;
    phase_left = 0;
    push_pct   = 50;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      if (items_sent == QUIET_START) no_gaps = 1'b1;
      if (items_sent == QUIET_END) no_gaps = 1'b0;
      // long hold-off on the result side while items keep coming
      if (items_sent == HOLD_AT) hold_request = 1'b1;
      offer_item(pick_operation(push_pct), pick_word());
      items_sent++;
      phase_left--;
    end
    in_ch.valid = 1'b0;

    // let every owed result come out, then a little longer for strays
    while (sb.owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.fails == 0 && sb.owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
